[design/lome_pkg.sv]
// Shared types and constants for the limit order matching engine.
package lome_pkg;

	localparam int unsigned MAX_ORDERS_DEF = 32;
	localparam int unsigned PRICE_BITS_DEF = 32;

	typedef enum logic [2:0] {
		KIND_TRADE     = 3'd0,
		KIND_RESTED    = 3'd1,
		KIND_FILLED    = 3'd2,
		KIND_CANCELLED = 3'd3,
		KIND_UNKNOWN   = 3'd4,
		KIND_REJECTED  = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FILL,
		ST_FREE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        mode;
		logic        side;
		logic [31:0] price;
		logic [31:0] quantity;
		logic [31:0] order_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] trade_id;
		logic [31:0] taker_id;
		logic [31:0] maker_id;
		logic [31:0] trade_price;
		logic [31:0] trade_quantity;
		logic [31:0] remaining_quantity;
		logic        last;
	} rsp_t;

	// classified command; price travels beside it at its own width
	typedef struct packed {
		logic        is_cancel;
		logic        side;
		logic [31:0] quantity;
		logic [31:0] order_id;
	} cmd_t;

endpackage

[design/limit_order_matching_engine.sv]
// Top level of the limit order matching engine: front end, command queue, back end.
//
//  channel  signals                  word   direction
//  request  req_valid/req_ready      req    in
//  result   rsp_valid/rsp_ready      rsp    out
//
// An insert is loaded into the back end; then each fill takes one book scan and a fill
// step; then, if quantity is left, a search for a free slot follows, and last the final
// word. A cancel takes one book scan and then the final word.
// The scan walks the book memory through its single read port.
// Reset empties the book and clears both id counters; no clearing pass is needed.
// A stalled result holds the back end; the front end and queue keep taking requests
// until the front register and both queue slots are full.
module limit_order_matching_engine import lome_pkg::*; #(
	parameter int unsigned MAX_ORDERS = MAX_ORDERS_DEF,
	parameter int unsigned PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int unsigned QW = $bits(cmd_t) + PRICE_BITS;

	logic                  f_valid;
	logic                  f_ready;
	cmd_t                  f_cmd;
	logic [PRICE_BITS-1:0] f_price;
	logic                  b_valid;
	logic                  b_ready;
	logic [QW-1:0]         b_data;
	cmd_t                  b_cmd;
	logic [PRICE_BITS-1:0] b_price;

	assign b_cmd   = b_data[QW-1:PRICE_BITS];
	assign b_price = b_data[PRICE_BITS-1:0];

	lome_front #(.PRICE_BITS(PRICE_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd),
		.cmd_price (f_price)
	);

	lome_cmdq #(.W(QW)) u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  ({f_cmd, f_price}),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	lome_back #(.MAX_ORDERS(MAX_ORDERS), .PRICE_BITS(PRICE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.cmd_price (b_price),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[design/lome_front.sv]
// Front end: accepts request words and classifies them into commands.
module lome_front import lome_pkg::*; #(
	parameter int unsigned PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  cmd_valid,
	input  logic                  cmd_ready,
	output cmd_t                  cmd,
	output logic [PRICE_BITS-1:0] cmd_price
);

	logic                  full_q;
	cmd_t                  cmd_q;
	logic [PRICE_BITS-1:0] price_q;

	assign req_ready = !full_q || cmd_ready;
	assign cmd_valid = full_q;
	assign cmd       = cmd_q;
	assign cmd_price = price_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (req_valid && req_ready) begin
			full_q <= 1'b1;
		end else if (cmd_ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_q.is_cancel <= req.mode;
			cmd_q.side      <= req.side;
			cmd_q.quantity  <= req.quantity;
			cmd_q.order_id  <= req.order_id;
			price_q         <= PRICE_BITS'(req.price);
		end
	end

endmodule

[design/lome_cmdq.sv]
// Two-entry command queue between front end and matching back end.
module lome_cmdq #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] slot_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = slot_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_data;
	end

endmodule

[design/lome_back.sv]
// Back end: book storage, sequential best-price scan, fills and result register.
module lome_back import lome_pkg::*; #(
	parameter int unsigned MAX_ORDERS = MAX_ORDERS_DEF,
	parameter int unsigned PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cmd_t                  cmd,
	input  logic [PRICE_BITS-1:0] cmd_price,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp
);

	localparam int unsigned AW = $clog2(MAX_ORDERS);
	localparam int unsigned CW = $clog2(MAX_ORDERS + 1);

	// book payload memory
	logic                  mem_side  [MAX_ORDERS];
	logic [PRICE_BITS-1:0] mem_price [MAX_ORDERS];
	logic [31:0]           mem_qty   [MAX_ORDERS];
	logic [31:0]           mem_id    [MAX_ORDERS];
	logic [MAX_ORDERS-1:0] valid_q;

	state_t state_q, state_d;

	logic                  is_cancel_q;
	logic                  side_q;
	logic [PRICE_BITS-1:0] price_q;
	logic [31:0]           rem_q;
	logic [31:0]           taker_q;
	logic [31:0]           next_order_q;
	logic [31:0]           next_trade_q;
	logic [CW-1:0]         nfill_q;
	logic [CW-1:0]         issue_q;
	kind_t                 final_kind_q;

	// read pipeline stage
	logic                  pend_s1;
	logic [AW-1:0]         idx_s1;
	logic                  vld_s1;
	logic                  rd_side_s1;
	logic [PRICE_BITS-1:0] rd_price_s1;
	logic [31:0]           rd_qty_s1;
	logic [31:0]           rd_id_s1;

	logic                  best_found_q;
	logic [AW-1:0]         best_idx_q;
	logic [PRICE_BITS-1:0] best_price_q;
	logic [31:0]           best_qty_q;
	logic [31:0]           best_id_q;

	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	logic                  can_emit;
	logic                  issue_more;
	logic                  scan_done;
	logic                  cand;
	logic                  elig;
	logic                  better;
	logic [31:0]           fill;
	logic [31:0]           rem_after;
	logic [31:0]           qty_after;
	logic                  free_here;
	logic                  emit;
	rsp_t                  emit_word;

	assign can_emit   = !rsp_valid_q || rsp_ready;
	assign issue_more = (issue_q != CW'(MAX_ORDERS));
	assign scan_done  = !issue_more && !pend_s1;
	assign fill       = (rem_q < best_qty_q) ? rem_q : best_qty_q;
	assign rem_after  = rem_q - fill;
	assign qty_after  = best_qty_q - fill;
	assign free_here  = issue_more && !valid_q[issue_q[AW-1:0]];
	assign cmd_ready  = (state_q == ST_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	// candidate evaluation on the word read last cycle
	always_comb begin
		elig   = vld_s1 && (rd_side_s1 != side_q) &&
			(side_q ? (rd_price_s1 <= price_q) : (rd_price_s1 >= price_q));
		if (!best_found_q) begin
			better = 1'b1;
		end else if (rd_price_s1 != best_price_q) begin
			better = side_q ? (rd_price_s1 < best_price_q) : (rd_price_s1 > best_price_q);
		end else begin
			better = rd_id_s1 < best_id_q;
		end
		if (is_cancel_q) begin
			cand = pend_s1 && vld_s1 && (rd_id_s1 == taker_q) && !best_found_q;
		end else begin
			cand = pend_s1 && elig && better;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (!cmd.is_cancel && (cmd.quantity == 32'd0)) state_d = ST_DONE;
					else state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					if (is_cancel_q) state_d = ST_DONE;
					else if (best_found_q) state_d = ST_FILL;
					else state_d = ST_FREE;
				end
			end
			ST_FILL: begin
				if (can_emit) begin
					if (rem_after == 32'd0) state_d = ST_DONE;
					else if (nfill_q == CW'(MAX_ORDERS - 1)) state_d = ST_FREE;
					else state_d = ST_SCAN;
				end
			end
			ST_FREE: begin
				if (!issue_more || free_here) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (can_emit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result word
	always_comb begin
		emit      = 1'b0;
		emit_word = '0;
		case (state_q)
			ST_FILL: begin
				emit                         = can_emit;
				emit_word.kind               = KIND_TRADE;
				emit_word.trade_id           = next_trade_q;
				emit_word.taker_id           = taker_q;
				emit_word.maker_id           = best_id_q;
				emit_word.trade_price        = 32'(best_price_q);
				emit_word.trade_quantity     = fill;
				emit_word.remaining_quantity = rem_after;
			end
			ST_DONE: begin
				emit               = can_emit;
				emit_word.kind     = final_kind_q;
				emit_word.taker_id = taker_q;
				emit_word.last     = 1'b1;
				if (final_kind_q == KIND_RESTED || final_kind_q == KIND_REJECTED) begin
					emit_word.remaining_quantity = rem_q;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			next_order_q <= '0;
			next_trade_q <= '0;
			rsp_valid_q  <= 1'b0;
			pend_s1      <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					pend_s1      <= 1'b0;
					best_found_q <= 1'b0;
					if (cmd_valid && !cmd.is_cancel) next_order_q <= next_order_q + 32'd1;
				end
				ST_SCAN: begin
					pend_s1 <= issue_more;
					if (cand) best_found_q <= 1'b1;
				end
				ST_FILL: begin
					if (can_emit) begin
						next_trade_q <= next_trade_q + 32'd1;
						best_found_q <= 1'b0;
						pend_s1      <= 1'b0;
						if (qty_after == 32'd0) valid_q[best_idx_q] <= 1'b0;
					end
				end
				ST_FREE: begin
					if (free_here) valid_q[issue_q[AW-1:0]] <= 1'b1;
				end
				ST_DONE: begin
					if (can_emit && final_kind_q == KIND_CANCELLED) valid_q[best_idx_q] <= 1'b0;
				end
				default: begin
					pend_s1 <= 1'b0;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (emit) rsp_q <= emit_word;
		case (state_q)
			ST_IDLE: begin
				is_cancel_q <= cmd.is_cancel;
				side_q      <= cmd.side;
				price_q     <= cmd_price;
				rem_q       <= cmd.quantity;
				issue_q     <= '0;
				nfill_q     <= '0;
				taker_q     <= cmd.is_cancel ? cmd.order_id : next_order_q;
				final_kind_q <= KIND_FILLED;
			end
			ST_SCAN: begin
				if (issue_more) begin
					idx_s1  <= issue_q[AW-1:0];
					vld_s1  <= valid_q[issue_q[AW-1:0]];
					issue_q <= issue_q + CW'(1);
				end
				if (cand) begin
					best_idx_q   <= idx_s1;
					best_price_q <= rd_price_s1;
					best_qty_q   <= rd_qty_s1;
					best_id_q    <= rd_id_s1;
				end
				if (scan_done) begin
					if (is_cancel_q) final_kind_q <= best_found_q ? KIND_CANCELLED : KIND_UNKNOWN;
					if (!best_found_q) issue_q <= '0;
				end
			end
			ST_FILL: begin
				if (can_emit) begin
					rem_q   <= rem_after;
					nfill_q <= nfill_q + CW'(1);
					issue_q <= '0;
					final_kind_q <= KIND_FILLED;
				end
			end
			ST_FREE: begin
				if (free_here) final_kind_q <= KIND_RESTED;
				else if (!issue_more) final_kind_q <= KIND_REJECTED;
				else issue_q <= issue_q + CW'(1);
			end
			default: begin
				nfill_q <= nfill_q;
			end
		endcase
	end

	// memory: one read port for the scan, one write port shared by fill and rest
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && issue_more) begin
			rd_side_s1  <= mem_side[issue_q[AW-1:0]];
			rd_price_s1 <= mem_price[issue_q[AW-1:0]];
			rd_qty_s1   <= mem_qty[issue_q[AW-1:0]];
			rd_id_s1    <= mem_id[issue_q[AW-1:0]];
		end
		if (state_q == ST_FILL && can_emit) begin
			mem_qty[best_idx_q] <= qty_after;
		end else if (state_q == ST_FREE && free_here) begin
			mem_side[issue_q[AW-1:0]]  <= side_q;
			mem_price[issue_q[AW-1:0]] <= price_q;
			mem_qty[issue_q[AW-1:0]]   <= rem_q;
			mem_id[issue_q[AW-1:0]]    <= taker_q;
		end
	end

	a_fill_has_maker: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> best_found_q)
		else $error("fill without a maker");

	a_scan_open_qty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !is_cancel_q) |-> rem_q != 32'd0)
		else $error("scan with nothing left to match");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (fill <= best_qty_q && fill <= rem_q && fill != 32'd0))
		else $error("bad fill quantity");

	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> nfill_q < CW'(MAX_ORDERS))
		else $error("too many fills for one order");

endmodule

[tb/sv/lome_checker.sv]
`timescale 1ns / 1ps
// Order book predictor and result checker for the matching engine.
module lome_checker import lome_pkg::*; #(
	parameter int unsigned MAX_ORDERS = MAX_ORDERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  rsp_t        rsp,
	output int unsigned fail_count,
	output int unsigned pending
);

	logic        book_valid [MAX_ORDERS];
	logic        book_side  [MAX_ORDERS];
	logic [31:0] book_price [MAX_ORDERS];
	logic [31:0] book_qty   [MAX_ORDERS];
	logic [31:0] book_id    [MAX_ORDERS];
	logic [31:0] order_seq;
	logic [31:0] trade_seq;
	rsp_t        expected_words[$];

	assign pending = unsigned'(expected_words.size());

	function automatic rsp_t make_word(kind_t k, logic [31:0] tid, logic [31:0] taker,
			logic [31:0] maker, logic [31:0] px, logic [31:0] qty, logic [31:0] rem,
			logic lst);
		rsp_t w;
		w.kind = k;
		w.trade_id = tid;
		w.taker_id = taker;
		w.maker_id = maker;
		w.trade_price = px;
		w.trade_quantity = qty;
		w.remaining_quantity = rem;
		w.last = lst;
		return w;
	endfunction

	task automatic queue_word(rsp_t w);
		expected_words = {expected_words, w};
	endtask

	// best crossing resting order on the far side, -1 if none
	function automatic int best_contra(logic buy, logic [31:0] limit);
		int best;
		logic better;
		best = -1;
		for (int i = 0; i < MAX_ORDERS; i++) begin
			if (!book_valid[i] || book_side[i] == buy) continue;
			if (buy ? (book_price[i] > limit) : (book_price[i] < limit)) continue;
			if (best < 0) begin
				best = i;
				continue;
			end
			if (book_price[i] != book_price[best])
				better = buy ? (book_price[i] < book_price[best]) : (book_price[i] > book_price[best]);
			else
				better = book_id[i] < book_id[best];
			if (better) best = i;
		end
		return best;
	endfunction

	task automatic match_order(req_t r);
		logic [31:0] rem;
		logic [31:0] taker;
		logic [31:0] fill;
		int m;
		int n;
		int slot;
		logic hit;
		if (r.mode) begin
			hit = 0;
			for (int i = 0; i < MAX_ORDERS && !hit; i++)
				if (book_valid[i] && book_id[i] == r.order_id) begin
					book_valid[i] = 0;
					hit = 1;
				end
			queue_word(make_word(hit ? KIND_CANCELLED : KIND_UNKNOWN, 0,
				r.order_id, 0, 0, 0, 0, 1'b1));
			return;
		end
		taker = order_seq;
		order_seq++;
		rem = r.quantity;
		n = 0;
		while (rem != 0 && n < MAX_ORDERS) begin
			m = best_contra(r.side, r.price);
			if (m < 0) break;
			fill = (rem < book_qty[m]) ? rem : book_qty[m];
			book_qty[m] -= fill;
			rem -= fill;
			queue_word(make_word(KIND_TRADE, trade_seq, taker, book_id[m],
				book_price[m], fill, rem, 1'b0));
			trade_seq++;
			n++;
			if (book_qty[m] == 0) book_valid[m] = 0;
		end
		if (rem == 0) begin
			queue_word(make_word(KIND_FILLED, 0, taker, 0, 0, 0, 0, 1'b1));
			return;
		end
		slot = -1;
		for (int i = MAX_ORDERS - 1; i >= 0; i--)
			if (!book_valid[i]) slot = i;
		if (slot < 0) begin
			queue_word(make_word(KIND_REJECTED, 0, taker, 0, 0, 0, rem, 1'b1));
			return;
		end
		book_valid[slot] = 1;
		book_side[slot] = r.side;
		book_price[slot] = r.price;
		book_qty[slot] = rem;
		book_id[slot] = taker;
		queue_word(make_word(KIND_RESTED, 0, taker, 0, 0, 0, rem, 1'b1));
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t e;
		if (!arst_n) begin
			fail_count = 0;
			order_seq = 0;
			trade_seq = 0;
			for (int i = 0; i < MAX_ORDERS; i++) book_valid[i] = 0;
			expected_words.delete();
		end else begin
			if (req_valid && req_ready) match_order(req);
			if (rsp_valid && rsp_ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word kind %0d", rsp.kind);
					fail_count++;
				end else begin
					e = expected_words.pop_front();
					check_field("kind", 32'(e.kind), 32'(rsp.kind));
					check_field("trade_id", e.trade_id, rsp.trade_id);
					check_field("taker_id", e.taker_id, rsp.taker_id);
					check_field("maker_id", e.maker_id, rsp.maker_id);
					check_field("trade_price", e.trade_price, rsp.trade_price);
					check_field("trade_quantity", e.trade_quantity, rsp.trade_quantity);
					check_field("remaining_quantity", e.remaining_quantity,
						rsp.remaining_quantity);
					check_field("last", 32'(e.last), 32'(rsp.last));
				end
			end
		end
	end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Stimulus top for the limit order matching engine.
module tb;
	import lome_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 900000;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	logic [31:0] issued_ids;

	limit_order_matching_engine uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	lome_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		rsp_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);

	// valid stays up between words unless the sender idles
	task automatic send_word(logic mode, logic side, logic [31:0] px, logic [31:0] qty,
			logic [31:0] oid);
		req_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		r.mode = mode;
		r.side = side;
		r.price = px;
		r.quantity = qty;
		r.order_id = oid;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		if (!mode) issued_ids++;
	endtask

	// mostly prices in a narrow band so orders cross, some full range
	task automatic random_word();
		logic [31:0] px;
		logic [31:0] qty;
		logic [31:0] oid;
		px = ($urandom_range(9) == 0) ? $urandom() : 32'd1000 + $urandom_range(20);
		case ($urandom_range(9))
			0: qty = $urandom();
			1: qty = 0;
			default: qty = $urandom_range(1, 50);
		endcase
		oid = ($urandom_range(3) == 0) ? $urandom() : issued_ids - $urandom_range(20);
		send_word($urandom_range(99) < 20, 1'($urandom_range(1)), px, qty, oid);
	endtask

	initial begin
		issued_ids = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 0;
		req_valid = 0;
		req = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: rest, cross at several levels, extremes, cancels
		send_word(1'b1, 1'b0, 0, 0, 32'd5);
		send_word(1'b0, 1'b0, 32'd100, 32'd10, 0);
		send_word(1'b0, 1'b0, 32'd100, 32'd5, 0);
		send_word(1'b0, 1'b0, 32'd99, 32'd3, 0);
		send_word(1'b0, 1'b1, 32'd100, 32'd15, 32'hFFFF_FFFF);
		send_word(1'b0, 1'b1, 32'd0, 0, 0);
		send_word(1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_word(1'b0, 1'b0, 32'd0, 32'd7, 0);
		send_word(1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_word(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd8);
		send_word(1'b1, 1'b0, 0, 0, 32'd8);
		send_word(1'b1, 1'b0, 0, 0, 32'hFFFF_FFFF);
		// fill the book with resting bids, then overflow, then sweep it
		for (int i = 0; i < 34; i++)
			send_word(1'b0, 1'b1, 32'd10 + (i % 3), 32'd1, 0);
		send_word(1'b0, 1'b0, 32'd0, 32'd40, 0);
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 72 : 0;
			recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 18 : 0;
			for (int i = 0; i < 38; i++) random_word();
		end
		req_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[limit_order_matching_engine.f]
design/lome_pkg.sv
design/lome_front.sv
design/lome_cmdq.sv
design/lome_back.sv
design/limit_order_matching_engine.sv
tb/sv/lome_checker.sv
tb/sv/tb.sv
